/* hdl/wmp_pkg.sv */
// ----------------------------------------------------------------------------
// wmp_pkg
// Shared constants, command codes and control structs of the Weyl-mix
// generator.
// ----------------------------------------------------------------------------
package wmp_pkg;

   localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] SM_MUL_A    = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] SM_MUL_B    = 64'h94d049bb133111eb;
   localparam logic [63:0] WEYL_STEP   = 64'h9999999999999999;

   localparam int WORD_W    = 64;
   localparam int IDX_W     = 16;
   localparam int CNT_W     = 17;
   localparam int CSR_IDX_W = 2;
   localparam int DIV_STEPS = 64;
   localparam int DIV_CNT_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_SEED_VALUE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_INDEX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_COUNT = 2'd2;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_DRAW,
      DP_SEED_LOAD,
      DP_SM_STEP,
      DP_MUL,
      DP_MIX,
      DP_STORE,
      DP_DIV_INIT,
      DP_DIV_STEP
   } dp_op_type;

   // which constant, or the divider quotient, the shared multiplier uses
   typedef enum logic [1:0] {
      MUL_A,
      MUL_B,
      MUL_Q
   } mul_sel_type;

   typedef enum logic [1:0] {
      WORD_MIX,
      WORD_LOOP,
      WORD_WEYL
   } word_sel_type;

   typedef struct packed {
      dp_op_type    op;
      logic [1:0]   phase;
      mul_sel_type  mul_sel;
      word_sel_type target;
   } dp_cmd_type;

   typedef struct packed {
      logic multi_stream;
   } dp_status_type;

endpackage

/* hdl/wmp_ctrl.sv */
// ----------------------------------------------------------------------------
// wmp_ctrl
// Handshake control and reseed sequencer of the Weyl-mix generator.
// ----------------------------------------------------------------------------
module wmp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  reseed,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  wmp_pkg::dp_status_type status,
   output wmp_pkg::dp_cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_SM       = 7'b0000010,
      ST_MUL      = 7'b0000100,
      ST_MIX      = 7'b0001000,
      ST_STORE    = 7'b0010000,
      ST_DIV_INIT = 7'b0100000,
      ST_DIV      = 7'b1000000
   } state_type;

   state_type                       state_ff, state_in;
   logic [1:0]                      phase_ff, phase_in;
   wmp_pkg::mul_sel_type            mul_sel_ff, mul_sel_in;
   wmp_pkg::word_sel_type           word_ff, word_in;
   logic [wmp_pkg::DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            req_accept;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      mul_sel_in   = mul_sel_ff;
      word_in      = word_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = wmp_pkg::DP_NOP;
      cmd.phase    = phase_ff;
      cmd.mul_sel  = mul_sel_ff;
      cmd.target   = word_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (reseed) begin
                  cmd.op   = wmp_pkg::DP_SEED_LOAD;
                  word_in  = wmp_pkg::WORD_MIX;
                  state_in = ST_SM;
               end else begin
                  cmd.op       = wmp_pkg::DP_DRAW;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SM: begin
            cmd.op     = wmp_pkg::DP_SM_STEP;
            mul_sel_in = wmp_pkg::MUL_A;
            phase_in   = 2'd0;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.op   = wmp_pkg::DP_MUL;
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               state_in = (mul_sel_ff == wmp_pkg::MUL_A) ? ST_MIX : ST_STORE;
            end
         end
         ST_MIX: begin
            cmd.op     = wmp_pkg::DP_MIX;
            mul_sel_in = wmp_pkg::MUL_B;
            phase_in   = 2'd0;
            state_in   = ST_MUL;
         end
         ST_STORE: begin
            cmd.op = wmp_pkg::DP_STORE;
            unique case (word_ff)
               wmp_pkg::WORD_MIX: begin
                  word_in  = wmp_pkg::WORD_LOOP;
                  state_in = ST_SM;
               end
               wmp_pkg::WORD_LOOP: begin
                  if (status.multi_stream) begin
                     state_in = ST_DIV_INIT;
                  end else begin
                     word_in  = wmp_pkg::WORD_WEYL;
                     state_in = ST_SM;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DIV_INIT: begin
            cmd.op     = wmp_pkg::DP_DIV_INIT;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.op     = wmp_pkg::DP_DIV_STEP;
            div_cnt_in = div_cnt_ff + wmp_pkg::DIV_CNT_W'(1);
            if (div_cnt_ff == wmp_pkg::DIV_CNT_W'(wmp_pkg::DIV_STEPS - 1)) begin
               mul_sel_in = wmp_pkg::MUL_Q;
               phase_in   = 2'd0;
               word_in    = wmp_pkg::WORD_WEYL;
               state_in   = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 2'd0;
         mul_sel_ff   <= wmp_pkg::MUL_A;
         word_ff      <= wmp_pkg::WORD_MIX;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         mul_sel_ff   <= mul_sel_in;
         word_ff      <= word_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

endmodule

/* hdl/wmp_datapath.sv */
// ----------------------------------------------------------------------------
// wmp_datapath
// Generator words, configuration registers, shared 32x32 multiplier and
// bit-serial divider for stream spacing.
// ----------------------------------------------------------------------------
module wmp_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [wmp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [63:0]                      csr_data,
   input  wmp_pkg::dp_cmd_type              cmd,
   output wmp_pkg::dp_status_type           status,
   output logic [wmp_pkg::WORD_W-1:0]       rsp_data
);

   localparam int W = wmp_pkg::WORD_W;
   localparam int H = W / 2;

   // configuration
   logic [W-1:0]              seed_ff;
   logic [wmp_pkg::IDX_W-1:0] idx_ff;
   logic [wmp_pkg::CNT_W-1:0] cnt_ff;

   // generator state
   logic [W-1:0] mix_ff, mix_in;
   logic [W-1:0] loop_ff, loop_in;
   logic [W-1:0] weyl_ff, weyl_in;

   // reseed working registers and the response register
   logic [W-1:0]              s_ff, s_in;
   logic [W-1:0]              z_ff, z_in;
   logic [W-1:0]              acc_ff, acc_in;
   logic [W-1:0]              prod_ff, prod_in;
   logic [W-1:0]              q_ff, q_in;
   logic [wmp_pkg::CNT_W-1:0] rem_ff, rem_in;
   logic [W-1:0]              rsp_ff, rsp_in;

   logic [W-1:0]              s_sum;
   logic [W-1:0]              mul_const;
   logic [H-1:0]              mul_x, mul_y;
   logic [W-1:0]              product;
   logic [W-1:0]              store_val;
   logic [wmp_pkg::CNT_W-1:0] cnt_m1;
   logic [wmp_pkg::IDX_W-1:0] idx_clamp;
   logic [wmp_pkg::CNT_W:0]   rem_sh;

   assign status.multi_stream = (cnt_ff > wmp_pkg::CNT_W'(1));
   assign rsp_data            = rsp_ff;

   assign cnt_m1    = cnt_ff - wmp_pkg::CNT_W'(1);
   assign idx_clamp = ({1'b0, idx_ff} >= cnt_ff) ? cnt_m1[wmp_pkg::IDX_W-1:0] : idx_ff;
   assign rem_sh    = {rem_ff, 1'b1};
   assign s_sum     = s_ff + wmp_pkg::GOLDEN_STEP;

   always_comb begin
      unique case (cmd.mul_sel)
         wmp_pkg::MUL_A: mul_const = wmp_pkg::SM_MUL_A;
         wmp_pkg::MUL_B: mul_const = wmp_pkg::SM_MUL_B;
         default:        mul_const = q_ff;
      endcase
   end

   // low 64 bits of z * const from three 32x32 partial products
   assign mul_x   = (cmd.phase == 2'd2) ? z_ff[W-1:H] : z_ff[H-1:0];
   assign mul_y   = (cmd.phase == 2'd1) ? mul_const[W-1:H] : mul_const[H-1:0];
   assign product = mul_x * mul_y;

   assign store_val = (cmd.mul_sel == wmp_pkg::MUL_Q) ? acc_ff : (acc_ff ^ (acc_ff >> 31));

   always_comb begin
      mix_in  = mix_ff;
      loop_in = loop_ff;
      weyl_in = weyl_ff;
      s_in    = s_ff;
      z_in    = z_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      rsp_in  = rsp_ff;

      unique case (cmd.op)
         wmp_pkg::DP_DRAW: begin
            rsp_in  = mix_ff + loop_ff;
            loop_in = weyl_ff ^ mix_ff;
            mix_in  = {mix_ff[W-17:0], mix_ff[W-1:W-16]}
                    + {loop_ff[W-41:0], loop_ff[W-1:W-40]};
            weyl_in = weyl_ff + wmp_pkg::WEYL_STEP;
         end
         wmp_pkg::DP_SEED_LOAD: begin
            s_in = seed_ff;
         end
         wmp_pkg::DP_SM_STEP: begin
            s_in = s_sum;
            z_in = s_sum ^ (s_sum >> 30);
         end
         wmp_pkg::DP_MUL: begin
            unique case (cmd.phase)
               2'd0: begin
                  prod_in = product;
               end
               2'd1: begin
                  acc_in  = prod_ff;
                  prod_in = product;
               end
               2'd2: begin
                  acc_in  = acc_ff + {prod_ff[H-1:0], {H{1'b0}}};
                  prod_in = product;
               end
               default: begin
                  acc_in = acc_ff + {prod_ff[H-1:0], {H{1'b0}}};
               end
            endcase
         end
         wmp_pkg::DP_MIX: begin
            z_in = acc_ff ^ (acc_ff >> 27);
         end
         wmp_pkg::DP_STORE: begin
            unique case (cmd.target)
               wmp_pkg::WORD_MIX:  mix_in  = store_val;
               wmp_pkg::WORD_LOOP: loop_in = store_val;
               default:            weyl_in = store_val;
            endcase
         end
         wmp_pkg::DP_DIV_INIT: begin
            rem_in = '0;
            q_in   = '0;
            z_in   = {{(W - wmp_pkg::IDX_W){1'b0}}, idx_clamp};
         end
         wmp_pkg::DP_DIV_STEP: begin
            // dividend is all ones, so a one shifts in every step
            if (rem_sh >= {1'b0, cnt_ff}) begin
               rem_in = wmp_pkg::CNT_W'(rem_sh - {1'b0, cnt_ff});
               q_in   = {q_ff[W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[wmp_pkg::CNT_W-1:0];
               q_in   = {q_ff[W-2:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         idx_ff  <= '0;
         cnt_ff  <= wmp_pkg::CNT_W'(1);
         mix_ff  <= '0;
         loop_ff <= '0;
         weyl_ff <= '0;
      end else begin
         mix_ff  <= mix_in;
         loop_ff <= loop_in;
         weyl_ff <= weyl_in;
         if (csr_we) begin
            unique case (csr_index)
               wmp_pkg::CSR_SEED_VALUE:   seed_ff <= csr_data;
               wmp_pkg::CSR_STREAM_INDEX: idx_ff  <= csr_data[wmp_pkg::IDX_W-1:0];
               wmp_pkg::CSR_STREAM_COUNT: cnt_ff  <= csr_data[wmp_pkg::CNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      z_ff    <= z_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

endmodule

/* hdl/weyl_mix_prng_with_seeding.sv */
// ----------------------------------------------------------------------------
// weyl_mix_prng_with_seeding
// 64-bit Weyl-counter / mix-word random generator with SplitMix64 seeding.
// ----------------------------------------------------------------------------
// A draw item (req_tdata bit 0 low) is taken and its 64-bit result sits in
// the output register; draws can follow every cycle as long as rsp_tready
// keeps the output register draining. A reseed item (bit 0 high) gives no
// result and holds off further items while the sequencer expands the seed
// into SplitMix64 outputs on the shared 32x32 multiplier: three of them for a
// plain reseed (stream count of one or zero), and two for a multi-stream
// reseed, whose Weyl word is the stream index times the quotient from the
// one-bit-per-cycle divider that spaces the streams.
// Configuration registers are written through the csr channel, which is
// always ready; write them only while no reseed is in progress.
// ----------------------------------------------------------------------------
module weyl_mix_prng_with_seeding (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [0] reseed, [7:1] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp_tdata: [63:0] random_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   wmp_pkg::dp_cmd_type    cmd;
   wmp_pkg::dp_status_type status;
   logic                   csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   wmp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .reseed     (req_tdata[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   wmp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_tdata)
   );

   // a reseed keeps the input closed on the next cycle
   a_reseed_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[0] |=> !req_tready)
      else $error("input open right after a reseed item");

   // a draw always leaves a result in the output register
   a_draw_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tdata[0] |=> rsp_tvalid)
      else $error("draw item produced no result");

   // a reseed never creates a result
   a_reseed_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[0] && !rsp_tvalid |=> !rsp_tvalid)
      else $error("reseed item produced a result");

endmodule
